@@ hw/rtl/sv32tlb_pkg.sv @@
// Shared constants, types and permission/address helpers for the Sv32 TLB.
`default_nettype none

package sv32tlb_pkg;

  // Number of TLB slots and the width of a slot index
  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Stream payload widths (tdata zero padded to whole bytes)
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 3;

  // Request kinds
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_WALK_RESP = 2'd1;
  localparam logic [1:0] OP_FLUSH     = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FAULT = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_BUSY  = 3'd4;
  localparam logic [2:0] ST_DROP  = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;

  // Access types
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;
  localparam logic [1:0] ACC_RSVD  = 2'd3;

  // Privilege levels
  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  // PTE permission bit positions
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_U = 4;
  localparam int PTE_G = 5;
  localparam int PTE_A = 6;
  localparam int PTE_D = 7;

  // satp translation mode bit
  localparam int SATP_MODE = 31;

  // One TLB slot, valid bit kept apart
  typedef struct packed {
    logic [8:0]  asid;
    logic [9:0]  vpn1;
    logic [9:0]  vpn0;
    logic [21:0] ppn;
    logic [7:0]  perm;
    logic        level;
  } tlb_entry_t;

  // Access context captured when a walk starts
  typedef struct packed {
    logic       sum;
    logic       mxr;
    logic [1:0] priv;
    logic [1:0] acc;
  } walk_ctx_t;

  // Sv32 leaf permission check
  function automatic logic perm_ok(input logic [7:0] perm, input logic [1:0] acc,
                                   input logic [1:0] prv, input logic sum,
                                   input logic mxr);
    logic ok;
    ok = 1'b1;
    if (acc == ACC_RSVD) ok = 1'b0;
    if (acc == ACC_FETCH && !perm[PTE_X]) ok = 1'b0;
    if (acc == ACC_LOAD && !perm[PTE_R] && !(mxr && perm[PTE_X])) ok = 1'b0;
    if (acc == ACC_STORE && !(perm[PTE_W] && perm[PTE_D])) ok = 1'b0;
    if (prv == PRIV_USER && !perm[PTE_U]) ok = 1'b0;
    if (prv == PRIV_SUPER && perm[PTE_U] && (acc == ACC_FETCH || !sum)) ok = 1'b0;
    if (!perm[PTE_A]) ok = 1'b0;
    return ok;
  endfunction

  // Physical address: ppn << 12 truncated to 32 bits, superpage keeps va[21:0]
  function automatic logic [31:0] compose_pa(input logic [31:0] va,
                                             input logic [21:0] ppn,
                                             input logic level);
    logic [31:0] pa;
    if (level) pa = {ppn[19:10], va[21:0]};
    else       pa = {ppn[19:0], va[11:0]};
    return pa;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sv32_tlb_translate.sv @@
// Sv32 TLB: fully associative lookup, permission check, single pending walk and refill.
//
// Usage:
//   Requests enter on the s_* stream; s_tuser carries the request kind
//   (translate, page walk response, flush) and s_tdata the address, access
//   type, satp, privilege/status bits and walk response fields.
//   Every request produces exactly one result on the m_* stream; m_tuser is
//   the status, m_tdata the physical address and the walk request fields.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while m_tready is high. All slots are
//   compared in parallel in the accept cycle, and the slot array, walk
//   registers and the result register are all updated at that same edge,
//   so the next request sees the updated state.
//   Reset: all slots invalid, replacement pointer zero, no walk pending,
//   no result held. A flush request has the same effect on the TLB state.
//   Stall: the result register holds while m_tready is low; a new request
//   is taken only in a cycle where the held result leaves or none is held.
`default_nettype none

module sv32_tlb_translate (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // tdata, low bit up: virtual_address[31:0], acc_kind[1:0], satp[31:0],
  // privilege[1:0], make_exec_readable, supervisor_user_access,
  // modify_privilege, previous_privilege[1:0], walk_leaf_pte[31:0],
  // walk_leaf_level, walk_fault, zero fill
  input  wire logic [sv32tlb_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: opcode[1:0]
  input  wire logic [sv32tlb_pkg::IN_USER_W-1:0]  s_tuser,
  // Result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tdata, low bit up: physical_address[31:0], walk_request_address[31:0],
  // walk_request_satp[31:0], walk_request_type[1:0], zero fill
  output logic [sv32tlb_pkg::OUT_DATA_W-1:0]     m_tdata,
  // tuser: result_status[2:0]
  output logic [sv32tlb_pkg::OUT_USER_W-1:0]     m_tuser
);

  import sv32tlb_pkg::*;

  // Request fields
  logic [1:0]  opcode;
  logic [31:0] virtual_address;
  logic [1:0]  acc_kind;
  logic [31:0] satp;
  logic [1:0]  privilege;
  logic        make_exec_readable;
  logic        supervisor_user_access;
  logic        modify_privilege;
  logic [1:0]  previous_privilege;
  logic [31:0] walk_leaf_pte;
  logic        walk_leaf_level;
  logic        walk_fault;

  assign opcode                 = s_tuser[1:0];
  assign virtual_address        = s_tdata[31:0];
  assign acc_kind               = s_tdata[33:32];
  assign satp                   = s_tdata[65:34];
  assign privilege              = s_tdata[67:66];
  assign make_exec_readable     = s_tdata[68];
  assign supervisor_user_access = s_tdata[69];
  assign modify_privilege       = s_tdata[70];
  assign previous_privilege     = s_tdata[72:71];
  assign walk_leaf_pte          = s_tdata[104:73];
  assign walk_leaf_level        = s_tdata[105];
  assign walk_fault             = s_tdata[106];

  // TLB state
  logic [SLOT_COUNT-1:0] valid;
  tlb_entry_t            entries [SLOT_COUNT];
  logic [IDX_W-1:0]      replace_ptr;
  logic                  walk_pending;
  logic [31:0]           walk_address;
  logic [31:0]           pend_satp;
  walk_ctx_t             walk_ctx;

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Effective privilege and bare/machine bypass
  logic [1:0] priv_sel;
  logic       bypass;
  assign priv_sel = (acc_kind != ACC_FETCH && modify_privilege) ?
                    previous_privilege : privilege;
  assign bypass   = (priv_sel == PRIV_MACHINE) || !satp[SATP_MODE];

  // Parallel tag match against every slot
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] hit_onehot;
  logic                  hit;
  tlb_entry_t            hit_entry;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = valid[i]
              && (entries[i].perm[PTE_G] || entries[i].asid == satp[30:22])
              && entries[i].vpn1 == virtual_address[31:22]
              && (entries[i].level || entries[i].vpn0 == virtual_address[21:12]);
    end
  end

  // Lowest-index match wins
  assign hit_onehot = match & ~(match - SLOT_COUNT'(1));
  assign hit        = |match;

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit_onehot[i]) hit_entry = hit_entry | entries[i];
    end
  end

  // Walk response against the pending page
  logic resp_match;
  logic resp_ok;
  logic same_page;
  assign same_page  = walk_address[31:12] == virtual_address[31:12];
  assign resp_match = walk_pending && same_page;
  assign resp_ok    = !walk_fault && perm_ok(walk_leaf_pte[7:0], walk_ctx.acc,
                                             walk_ctx.priv, walk_ctx.sum, walk_ctx.mxr);

  // Result and next-state decode
  logic [2:0]  res_status;
  logic [31:0] res_pa;
  logic [31:0] res_wa;
  logic [31:0] res_ws;
  logic [1:0]  res_wt;
  logic        start_walk;
  logic        end_walk;
  logic        refill;
  logic        flush;

  always_comb begin
    res_status = ST_DROP;
    res_pa     = '0;
    res_wa     = '0;
    res_ws     = '0;
    res_wt     = '0;
    start_walk = 1'b0;
    end_walk   = 1'b0;
    refill     = 1'b0;
    flush      = 1'b0;
    case (opcode)
      OP_TRANSLATE: begin
        if (bypass) begin
          res_status = ST_OK;
          res_pa     = virtual_address;
        end else if (hit) begin
          if (perm_ok(hit_entry.perm, acc_kind, priv_sel,
                      supervisor_user_access, make_exec_readable)) begin
            res_status = ST_OK;
            res_pa     = compose_pa(virtual_address, hit_entry.ppn, hit_entry.level);
          end else begin
            res_status = ST_FAULT;
          end
        end else if (!walk_pending) begin
          start_walk = 1'b1;
          res_status = ST_WALK;
          res_wa     = virtual_address;
          res_ws     = satp;
          res_wt     = acc_kind;
        end else if (same_page && pend_satp == satp) begin
          res_status = ST_WAIT;
        end else begin
          res_status = ST_BUSY;
        end
      end
      OP_WALK_RESP: begin
        if (resp_match) begin
          end_walk = 1'b1;
          if (resp_ok) begin
            refill     = 1'b1;
            res_status = ST_OK;
            res_pa     = compose_pa(walk_address, walk_leaf_pte[31:10], walk_leaf_level);
          end else begin
            res_status = ST_FAULT;
          end
        end
      end
      OP_FLUSH: begin
        flush      = 1'b1;
        res_status = ST_FLUSH;
      end
      default: begin
        res_status = ST_DROP;
      end
    endcase
  end

  // Control state: valid bits, pointer, walk tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      replace_ptr  <= '0;
      walk_pending <= 1'b0;
      walk_address <= '0;
      pend_satp    <= '0;
      walk_ctx     <= '0;
    end else if (accept) begin
      if (flush) begin
        valid        <= '0;
        replace_ptr  <= '0;
        walk_pending <= 1'b0;
        walk_address <= '0;
        pend_satp    <= '0;
        walk_ctx     <= '0;
      end else if (start_walk) begin
        walk_pending <= 1'b1;
        walk_address <= virtual_address;
        pend_satp    <= satp;
        walk_ctx     <= '{sum: supervisor_user_access, mxr: make_exec_readable,
                          priv: priv_sel, acc: acc_kind};
      end else if (end_walk) begin
        walk_pending <= 1'b0;
        walk_address <= '0;
        pend_satp    <= '0;
        walk_ctx     <= '0;
        if (refill) begin
          valid[replace_ptr] <= 1'b1;
          replace_ptr <= (replace_ptr == IDX_W'(SLOT_COUNT - 1)) ? '0 :
                         replace_ptr + IDX_W'(1);
        end
      end
    end
  end

  // Slot payload, written on refill
  always_ff @(posedge clk) begin
    if (accept && refill) begin
      entries[replace_ptr] <= '{asid:  pend_satp[30:22],
                                vpn1:  walk_address[31:22],
                                vpn0:  walk_address[21:12],
                                ppn:   walk_leaf_pte[31:10],
                                perm:  walk_leaf_pte[7:0],
                                level: walk_leaf_level};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= res_status;
      m_tdata <= {6'd0, res_wt, res_ws, res_wa, res_pa};
    end
  end

  // Checks
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_FLUSH |=> valid == '0 && !walk_pending)
    else $error("flush left valid slots or a pending walk");

  a_walk_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res_status == ST_WALK |-> !walk_pending)
    else $error("walk requested while another walk is pending");

  a_walk_sets_pending: assert property (@(posedge clk) disable iff (rst)
    accept && res_status == ST_WALK |=> walk_pending)
    else $error("walk request did not mark the walk pending");

  a_refill_fills: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_WALK_RESP && res_status == ST_OK |=> valid != '0 && !walk_pending)
    else $error("successful walk response did not refill a slot");

  a_wait_needs_pending: assert property (@(posedge clk) disable iff (rst)
    accept && (res_status == ST_WAIT || res_status == ST_BUSY) |-> walk_pending)
    else $error("wait or busy reported with no walk pending");

endmodule

`default_nettype wire

@@ tb/sv/sv32_tlb_translate_tb_pkg.sv @@
// Request/result types and the shadow TLB that predicts and checks the block's results.
package sv32_tlb_translate_tb_pkg;

  import sv32tlb_pkg::*;

  // One request as driven on the slave side
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] va;
    logic [1:0]  acc;
    logic [31:0] satp;
    logic [1:0]  priv;
    logic        mxr;
    logic        sum;
    logic        mprv;
    logic [1:0]  mpp;
    logic [31:0] pte;
    logic        lvl;
    logic        flt;
  } tlb_req_t;

  // One translation result as seen on the master side
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pa;
    logic [31:0] walk_va;
    logic [31:0] req_satp;
    logic [1:0]  walk_acc;
  } xlat_result_t;

  class tlb_shadow;
    logic             slot_valid [SLOT_COUNT];
    tlb_entry_t       slot [SLOT_COUNT];
    logic [IDX_W-1:0] refill_ptr;
    logic             walk_busy;
    logic [31:0]      walk_va;
    logic [31:0]      pend_satp;
    walk_ctx_t        walk_ctx;
    xlat_result_t     expected_xlat[$];
    int               mismatches;

    function new();
      clear_tlb();
      mismatches = 0;
    endfunction

    // Reset and flush both land here
    function void clear_tlb();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid[i] = 1'b0;
        slot[i] = '0;
      end
      refill_ptr = '0;
      walk_busy = 1'b0;
      walk_va = '0;
      pend_satp = '0;
      walk_ctx = '0;
    endfunction

    // Leaf permission rules for one access
    function logic access_allowed(logic [7:0] perm, logic [1:0] acc, logic [1:0] prv,
                                  logic sum, logic mxr);
      logic granted;
      case (acc)
        ACC_FETCH: granted = perm[PTE_X];
        ACC_LOAD:  granted = perm[PTE_R] || (mxr && perm[PTE_X]);
        ACC_STORE: granted = perm[PTE_W] && perm[PTE_D];
        default:   granted = 1'b0;
      endcase
      if (!perm[PTE_A]) granted = 1'b0;
      if (prv == PRIV_USER && !perm[PTE_U]) granted = 1'b0;
      // supervisor never fetches from user pages, data only with SUM
      if (prv == PRIV_SUPER && perm[PTE_U] && (acc == ACC_FETCH || !sum)) granted = 1'b0;
      return granted;
    endfunction

    // ppn << 12 truncated to 32 bits; a superpage keeps va[21:0]
    function logic [31:0] phys_addr(logic [31:0] va, logic [21:0] ppn, logic lvl);
      logic [33:0] base;
      base = {ppn, 12'h000};
      return lvl ? {base[31:22], va[21:0]} : {base[31:12], va[11:0]};
    endfunction

    // Accepted request: update the shadow state and queue the expected result
    function void note_request(tlb_req_t r);
      xlat_result_t res;
      logic [1:0]   eff;
      logic         found;
      tlb_entry_t   hit;
      res = '0;
      res.status = ST_DROP;
      found = 1'b0;
      hit = '0;
      case (r.op)
        OP_TRANSLATE: begin
          eff = (r.acc != ACC_FETCH && r.mprv) ? r.mpp : r.priv;
          if (eff == PRIV_MACHINE || !r.satp[SATP_MODE]) begin
            res.status = ST_OK;
            res.pa = r.va;
          end else begin
            // lowest index match wins; global pages ignore the ASID
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (!found && slot_valid[i] &&
                  (slot[i].perm[PTE_G] || slot[i].asid == r.satp[30:22]) &&
                  slot[i].vpn1 == r.va[31:22] &&
                  (slot[i].level || slot[i].vpn0 == r.va[21:12])) begin
                found = 1'b1;
                hit = slot[i];
              end
            end
            if (found) begin
              if (access_allowed(hit.perm, r.acc, eff, r.sum, r.mxr)) begin
                res.status = ST_OK;
                res.pa = phys_addr(r.va, hit.ppn, hit.level);
              end else begin
                res.status = ST_FAULT;
              end
            end else if (!walk_busy) begin
              walk_busy = 1'b1;
              walk_va = r.va;
              pend_satp = r.satp;
              walk_ctx = '{sum: r.sum, mxr: r.mxr, priv: eff, acc: r.acc};
              res.status = ST_WALK;
              res.walk_va = r.va;
              res.req_satp = r.satp;
              res.walk_acc = r.acc;
            end else if (walk_va[31:12] == r.va[31:12] && pend_satp == r.satp) begin
              res.status = ST_WAIT;
            end else begin
              res.status = ST_BUSY;
            end
          end
        end
        OP_WALK_RESP: begin
          // only a response for the pending page counts
          if (walk_busy && walk_va[31:12] == r.va[31:12]) begin
            walk_busy = 1'b0;
            if (r.flt || !access_allowed(r.pte[7:0], walk_ctx.acc, walk_ctx.priv,
                                         walk_ctx.sum, walk_ctx.mxr)) begin
              res.status = ST_FAULT;
            end else begin
              slot[refill_ptr] = '{asid: pend_satp[30:22], vpn1: walk_va[31:22],
                                   vpn0: walk_va[21:12], ppn: r.pte[31:10],
                                   perm: r.pte[7:0], level: r.lvl};
              slot_valid[refill_ptr] = 1'b1;
              refill_ptr = (refill_ptr == IDX_W'(SLOT_COUNT - 1)) ? '0 :
                           refill_ptr + IDX_W'(1);
              res.status = ST_OK;
              res.pa = phys_addr(walk_va, r.pte[31:10], r.lvl);
            end
            walk_va = '0;
            pend_satp = '0;
            walk_ctx = '0;
          end
        end
        OP_FLUSH: begin
          clear_tlb();
          res.status = ST_FLUSH;
        end
        default: ;
      endcase
      expected_xlat.push_back(res);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Accepted result: match against the oldest expectation
    function void check_result(logic [OUT_USER_W-1:0] status, logic [OUT_DATA_W-1:0] data);
      xlat_result_t want;
      if (expected_xlat.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: expected nothing actual status %0d data %h",
                 $time, status, data);
        return;
      end
      want = expected_xlat.pop_front();
      compare("result_status", 32'(want.status), 32'(status));
      compare("physical_address", want.pa, data[31:0]);
      compare("walk_request_address", want.walk_va, data[63:32]);
      compare("walk_request_satp", want.req_satp, data[95:64]);
      compare("walk_request_type", 32'(want.walk_acc), 32'(data[97:96]));
    endfunction
  endclass

endpackage

@@ tb/sv/sv32_tlb_translate_tb.sv @@
// Top-level testbench for the Sv32 TLB: drives requests, stalls results, checks each one.
module sv32_tlb_translate_tb;

  import sv32tlb_pkg::*;
  import sv32_tlb_translate_tb_pkg::*;

  localparam logic [1:0] OP_RESERVED   = 2'd3;
  localparam logic [1:0] PRIV_RESERVED = 2'd2;
  localparam int RANDOM_REQS = 1700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [IN_USER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  tlb_req_t  cur_req = '0;
  tlb_shadow sb;
  logic      calm = 1'b0;
  logic [19:0] page_pool [8];
  logic [31:0] satp_pool [3];

  always #5 clk = ~clk;

  // tdata, low bit up: va, access type, satp, privilege, MXR, SUM, MPRV, MPP, pte, level, fault
  assign s_tdata = {{(IN_DATA_W - 107){1'b0}}, cur_req.flt, cur_req.lvl, cur_req.pte,
                    cur_req.mpp, cur_req.mprv, cur_req.sum, cur_req.mxr, cur_req.priv,
                    cur_req.satp, cur_req.acc, cur_req.va};
  assign s_tuser = cur_req.op;

  sv32_tlb_translate i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Monitor both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (s_tvalid && s_tready) sb.note_request(cur_req);
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side backpressure
  initial begin
    int gap;
    wait (!rst);
    forever begin
      m_tready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Move to the next falling edge, idling the request side for a while
  task automatic take_turn();
    int gap;
    @(negedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Present one request and hold it until accepted
  task automatic present(tlb_req_t r);
    cur_req = r;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic xlat(logic [31:0] va, logic [1:0] acc, logic [31:0] satp, logic [1:0] priv,
                      logic mxr = 1'b0, logic sum = 1'b0, logic mprv = 1'b0,
                      logic [1:0] mpp = PRIV_USER);
    tlb_req_t r;
    r = '0;
    r.op = OP_TRANSLATE;
    r.va = va;
    r.acc = acc;
    r.satp = satp;
    r.priv = priv;
    r.mxr = mxr;
    r.sum = sum;
    r.mprv = mprv;
    r.mpp = mpp;
    take_turn();
    present(r);
  endtask

  task automatic walk_resp(logic [31:0] va, logic [31:0] pte, logic lvl, logic flt);
    tlb_req_t r;
    r = '0;
    r.op = OP_WALK_RESP;
    r.va = va;
    r.pte = pte;
    r.lvl = lvl;
    r.flt = flt;
    take_turn();
    present(r);
  endtask

  // Flush or reserved opcode, other fields random
  task automatic plain_op(logic [1:0] op);
    tlb_req_t r;
    r = {op, $urandom, 2'($urandom), $urandom, 2'($urandom), 3'($urandom), 2'($urandom),
         $urandom, 2'($urandom)};
    take_turn();
    present(r);
  endtask

  // Mostly sane leaf permissions: D A G U X W R V
  function automatic logic [7:0] good_perm();
    return {$urandom_range(0, 9) < 8, $urandom_range(0, 9) < 9, $urandom_range(0, 4) == 0,
            $urandom_range(0, 1) == 1, $urandom_range(0, 9) < 8, $urandom_range(0, 9) < 8,
            $urandom_range(0, 19) < 17, 1'b1};
  endfunction

  function automatic logic [31:0] pool_va();
    return {page_pool[$urandom_range(0, 7)], 12'($urandom)};
  endfunction

  // Random request shaped by the current walk state
  task automatic build_random(output tlb_req_t r);
    int pick;
    int pv;
    pick = $urandom_range(0, 99);
    r = '0;
    r.lvl = 1'($urandom);
    if (sb.walk_busy && pick < 30) begin
      // response for the pending walk
      r.op = OP_WALK_RESP;
      r.va = {sb.walk_va[31:12], 12'($urandom)};
      r.pte = ($urandom_range(0, 9) < 8) ? {22'($urandom), 2'($urandom), good_perm()}
                                         : $urandom;
      r.flt = $urandom_range(0, 19) == 0;
    end else if (pick >= 90 && pick < 96) begin
      // stray response
      r.op = OP_WALK_RESP;
      r.va = ($urandom_range(0, 1) == 1) ? pool_va() : $urandom;
      r.pte = $urandom;
      r.flt = 1'($urandom);
    end else if (pick == 96) begin
      r = {OP_FLUSH, $urandom, 2'($urandom), $urandom, 2'($urandom), 3'($urandom),
           2'($urandom), $urandom, 2'($urandom)};
    end else if (pick == 97) begin
      r = {OP_RESERVED, $urandom, 2'($urandom), $urandom, 2'($urandom), 3'($urandom),
           2'($urandom), $urandom, 2'($urandom)};
    end else begin
      r.op = OP_TRANSLATE;
      r.va = ($urandom_range(0, 99) < 85) ? pool_va() : $urandom;
      r.satp = ($urandom_range(0, 9) < 9) ? satp_pool[$urandom_range(0, 2)] : $urandom;
      pv = $urandom_range(0, 9);
      r.priv = (pv < 4) ? PRIV_USER : (pv < 8) ? PRIV_SUPER :
               (pv == 8) ? PRIV_MACHINE : PRIV_RESERVED;
      r.acc = ($urandom_range(0, 19) == 0) ? ACC_RSVD : 2'($urandom_range(0, 2));
      r.mxr = 1'($urandom);
      r.sum = 1'($urandom);
      r.mprv = $urandom_range(0, 3) == 0;
      r.mpp = 2'($urandom);
      r.pte = $urandom;
      r.flt = 1'($urandom);
    end
  endtask

  // Stop sending until every result is back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_xlat.size() != 0) @(negedge clk);
  endtask

  initial begin
    tlb_req_t r;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] va_a;
    logic [31:0] va_b;
    logic [31:0] va_c;
    sb = new();
    s1 = {1'b1, 9'h005, 22'h000000};
    s2 = {1'b1, 9'h1FF, 22'h3FFFFF};
    va_a = 32'h0040_3ABC;
    va_b = 32'hFFC1_2345;
    va_c = 32'h0080_1000;
    // small page pool; some entries share vpn1 so superpages cover them
    for (int i = 0; i < 8; i++) page_pool[i] = 20'($urandom);
    page_pool[1][19:10] = page_pool[0][19:10];
    page_pool[2][19:10] = page_pool[0][19:10];
    page_pool[5][19:10] = page_pool[4][19:10];
    satp_pool[0] = {1'b1, 9'($urandom), 22'($urandom)};
    satp_pool[1] = {1'b1, 9'($urandom), 22'($urandom)};
    satp_pool[2] = {1'b1, 9'h000, satp_pool[0][21:0]};

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: bypass cases
    xlat(32'hFFFF_FFFF, ACC_LOAD, 32'h7FFF_FFFF, PRIV_USER);
    xlat(32'h0000_0000, ACC_STORE, s1, PRIV_MACHINE);
    xlat(32'h1234_5678, ACC_LOAD, s1, PRIV_USER, 1'b0, 1'b0, 1'b1, PRIV_MACHINE);
    // miss, wait, busy, stray response, refill with ppn truncated
    xlat(va_a, ACC_LOAD, s1, PRIV_USER);
    xlat(va_a + 32'h100, ACC_FETCH, s1, PRIV_USER);
    xlat(va_a, ACC_LOAD, s2, PRIV_USER);
    walk_resp(32'h0050_0000, {22'h3FFFFF, 2'b00, 8'hDF}, 1'b0, 1'b0);
    walk_resp(va_a, {22'h3FFFFF, 2'b00, 8'hDF}, 1'b0, 1'b0);
    // hits on a user page under each privilege rule
    xlat(va_a, ACC_STORE, s1, PRIV_USER);
    xlat(va_a, ACC_FETCH, s1, PRIV_SUPER);
    xlat(va_a, ACC_LOAD, s1, PRIV_SUPER, 1'b0, 1'b0);
    xlat(va_a, ACC_LOAD, s1, PRIV_SUPER, 1'b0, 1'b1);
    xlat(va_a, ACC_RSVD, s1, PRIV_USER);
    xlat(va_a, ACC_LOAD, s1, PRIV_RESERVED);
    // global execute-only superpage, MXR on and off, foreign ASID
    xlat(va_b, ACC_FETCH, s2, PRIV_SUPER);
    walk_resp(va_b, {22'h2AAAAA, 2'b00, 8'h69}, 1'b1, 1'b0);
    xlat(va_b ^ 32'h003F_F000, ACC_LOAD, s1, PRIV_SUPER, 1'b1);
    xlat(va_b ^ 32'h003F_F000, ACC_LOAD, s1, PRIV_SUPER, 1'b0);
    // store walk answered with a clean page fails the stored context check
    xlat(va_c, ACC_STORE, s1, PRIV_SUPER);
    walk_resp(va_c, {22'h000123, 2'b00, 8'h47}, 1'b0, 1'b0);
    walk_resp(va_c, {22'h000123, 2'b00, 8'hDF}, 1'b0, 1'b0);
    xlat(va_c, ACC_LOAD, s1, PRIV_USER);
    walk_resp(va_c, {22'h000123, 2'b00, 8'hDF}, 1'b0, 1'b1);
    plain_op(OP_RESERVED);
    plain_op(OP_FLUSH);
    xlat(va_a, ACC_LOAD, s1, PRIV_USER);

    // Random traffic
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 250 == 0) calm = $urandom_range(0, 3) == 0;
      if (n == 600 || n == 1200) wait_drained();
      take_turn();
      build_random(r);
      present(r);
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_xlat.size() == 0)
      $display("sv32_tlb_translate_tb: PASS");
    else
      $display("sv32_tlb_translate_tb: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #7_000_000;
    $display("sv32_tlb_translate_tb: FAIL");
    $finish;
  end

endmodule
